// ----- rtl/gb3_pkg.sv -----
// ----------------------------------------------------------------------------
// gb3_pkg: shared types and constants of the 3x3 rgb gaussian blur
// Payload structs, item control word, window column, sizes and codes.
// ----------------------------------------------------------------------------
`default_nettype none

package gb3_pkg;

  // frame geometry
  localparam int MAX_WIDTH    = 2048;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 16;
  localparam int CFG_DATA_W   = (CFG_HEIGHT_W > CFG_WIDTH_W) ? CFG_HEIGHT_W : CFG_WIDTH_W;
  localparam int CFG_IDX_W    = 1;
  localparam int ROW_W        = CFG_HEIGHT_W;
  localparam int WEXT_W       = (CFG_WIDTH_W > ADDR_W + 1) ? CFG_WIDTH_W : ADDR_W + 1;

  // register reset values, stored as size minus one
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int WM1_RESET    = ((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET) - 1;
  localparam int HM1_RESET    = HEIGHT_RESET - 1;

  // pixel layout
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;
  localparam int PIX_W    = NUM_CHAN * CHAN_W;
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  // kernel sums: column 1-2-1, then row 1-2-1, then divide by 16
  localparam int VSUM_W       = CHAN_W + 2;
  localparam int HSUM_W       = CHAN_W + 4;
  localparam int KERNEL_SHIFT = 4;
  localparam int WIN_COLS     = 3;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // how the result of an item is formed
  typedef enum logic [1:0] {
    KIND_BLUR      = 2'd0,
    KIND_CENTER    = 2'd1,
    KIND_DRAIN_MID = 2'd2,
    KIND_DRAIN_UP  = 2'd3
  } kind_t;

  typedef struct packed {
    logic              operation;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              last_of_frame;
  } pixel_out_t;

  // control word of one accepted item
  typedef struct packed {
    logic              wr;
    logic              emit;
    kind_t             kind;
    logic              last;
    logic [ADDR_W-1:0] addr;
  } item_t;

  // one window column: center pixel and per-channel 1-2-1 column sum
  typedef struct packed {
    logic [PIX_W-1:0]                 mid;
    logic [NUM_CHAN-1:0][VSUM_W-1:0]  vsum;
  } col_t;

  function automatic logic [CHAN_W-1:0] pix_chan(input logic [PIX_W-1:0] px, input int k);
    return px[k*CHAN_W +: CHAN_W];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gb3_ram.sv -----
// ----------------------------------------------------------------------------
// gb3_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/gb3_cell.sv -----
// ----------------------------------------------------------------------------
// gb3_cell: one column of the 3x3 window
// Holds a column and hands it to the next cell on every pixel shift.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  gb3_pkg::col_t col_in,
  output gb3_pkg::col_t col
);

  import gb3_pkg::*;

  // column register, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gb3_seq.sv -----
// ----------------------------------------------------------------------------
// gb3_seq: frame sequencer
// Size registers, input and output position counters, per-item decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_seq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gb3_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             accept,
  input  logic                             operation,
  output gb3_pkg::item_t                   item
);

  import gb3_pkg::*;

  logic [ADDR_W-1:0] wm1, wm1_next;
  logic [ROW_W-1:0]  hm1, hm1_next;
  logic [ADDR_W-1:0] in_col, in_col_next;
  logic [ROW_W-1:0]  in_row, in_row_next;
  logic [ADDR_W-1:0] out_col, out_col_next;
  logic [ROW_W-1:0]  out_row, out_row_next;
  logic              pixel_phase;
  logic              interior;
  logic              last;
  logic [WEXT_W-1:0] wext;

  // item decisions from the current positions
  always_comb begin
    pixel_phase = (in_row <= hm1);
    interior    = (out_row != '0) && (out_row < hm1) && (out_col != '0) && (out_col < wm1);
    last        = (out_row == hm1) && (out_col == wm1);
    item        = '0;
    item.last   = last;
    item.addr   = in_col;
    if (pixel_phase) begin
      if (operation == OP_PIXEL) begin
        item.wr   = 1'b1;
        item.emit = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_col != '0));
        item.kind = interior ? KIND_BLUR : KIND_CENTER;
      end
    end else begin
      item.emit = 1'b1;
      item.addr = out_col;
      item.kind = (out_row >= hm1) ? KIND_DRAIN_MID : KIND_DRAIN_UP;
    end
  end

  // counter and register updates
  always_comb begin
    wext         = WEXT_W'(cfg_data[CFG_WIDTH_W-1:0]);
    wm1_next     = wm1;
    hm1_next     = hm1;
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (cfg_write) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH: begin
          if (wext == '0) begin
            wm1_next = '0;
          end else if (wext > WEXT_W'(MAX_WIDTH)) begin
            wm1_next = ADDR_W'(MAX_WIDTH - 1);
          end else begin
            wm1_next = ADDR_W'(wext - WEXT_W'(1));
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_data[CFG_HEIGHT_W-1:0] == '0) begin
            hm1_next = '0;
          end else begin
            hm1_next = cfg_data[CFG_HEIGHT_W-1:0] - ROW_W'(1);
          end
        end
      endcase
    end else if (accept) begin
      // input position moves on pixels
      if (item.wr) begin
        if (in_col == wm1) begin
          in_col_next = '0;
          in_row_next = in_row + ROW_W'(1);
        end else begin
          in_col_next = in_col + ADDR_W'(1);
        end
      end
      // output position moves on results, frame end restarts everything
      if (item.emit) begin
        if (last) begin
          in_col_next  = '0;
          in_row_next  = '0;
          out_col_next = '0;
          out_row_next = '0;
        end else if (out_col == wm1) begin
          out_col_next = '0;
          out_row_next = out_row + ROW_W'(1);
        end else begin
          out_col_next = out_col + ADDR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wm1     <= ADDR_W'(WM1_RESET);
      hm1     <= ROW_W'(HM1_RESET);
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      wm1     <= wm1_next;
      hm1     <= hm1_next;
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gb3_fifo.sv -----
// ----------------------------------------------------------------------------
// gb3_fifo: result queue
// Small register queue between the filter pipeline and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gb3_pkg::pixel_out_t push_data,
  input  logic                pop,
  output logic                valid,
  output gb3_pkg::pixel_out_t data
);

  import gb3_pkg::*;

  pixel_out_t            mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [OCC_W-1:0]      count;

  assign valid = (count != '0);
  assign data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + OCC_W'(push) - OCC_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gaussian_blur_3x3_rgb.sv -----
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_rgb: 3x3 gaussian blur on a raster rgb pixel stream
// Throughput one transaction per clock while pix_stall is low; a result
// passes the stage 1 and stage 2 registers and the result queue before it
// is offered. Results trail the input stream by width+1 transactions; drain
// transactions flush the end of a frame. A 4-entry result queue with a
// credit count sets pix_stall. Reset clears counters, pipeline and queue
// and loads 640x480; the line stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_3x3_rgb (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pix_valid,
  output logic                           pix_stall,
  input  gb3_pkg::pixel_in_t             pix,
  output logic                           res_valid,
  input  logic                           res_stall,
  output gb3_pkg::pixel_out_t            res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gb3_pkg::CFG_DATA_W-1:0] cfg_data
);

  import gb3_pkg::*;

  logic              accept;
  logic              pop;
  logic              push;
  item_t             seq_item;
  logic [OCC_W-1:0]  occ, occ_next;

  logic              s1_valid;
  item_t             s1_item;
  logic [PIX_W-1:0]  s1_px;
  logic              s1_wr;
  logic              fwd_hit;
  logic [PIX_W-1:0]  fwd_up;
  logic [PIX_W-1:0]  fwd_mid;
  logic [PIX_W-1:0]  up_rdata;
  logic [PIX_W-1:0]  mid_rdata;
  logic [PIX_W-1:0]  u_res;
  logic [PIX_W-1:0]  m_res;
  col_t              new_col;
  col_t              chain [WIN_COLS+1];

  logic              s2_valid;
  item_t             s2_item;
  logic [PIX_W-1:0]  s2_drain_val;
  logic [HSUM_W-1:0] hsum [NUM_CHAN];
  logic [PIX_W-1:0]  blur_px;
  logic [PIX_W-1:0]  result_px;
  pixel_out_t        push_data;

  // handshakes and credits for queued results
  assign cfg_ready = 1'b1;
  assign pix_stall = (occ == OCC_W'(FIFO_DEPTH));
  assign accept    = pix_valid && !pix_stall;
  assign pop       = res_valid && !res_stall;
  assign occ_next  = occ + OCC_W'(accept && seq_item.emit) - OCC_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  // frame sequencer
  gb3_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .operation (pix.operation),
    .item      (seq_item)
  );

  // line stores, read at acceptance, written in the cycle after
  gb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk     (clk),
    .wr_en   (s1_wr),
    .wr_addr (s1_item.addr),
    .wr_data (m_res),
    .rd_addr (seq_item.addr),
    .rd_data (up_rdata)
  );

  gb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk     (clk),
    .wr_en   (s1_wr),
    .wr_addr (s1_item.addr),
    .wr_data (s1_px),
    .rd_addr (seq_item.addr),
    .rd_data (mid_rdata)
  );

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= accept;
      fwd_hit  <= s1_wr && (seq_item.addr == s1_item.addr);
    end
  end

  // stage 1 payload and write forwarding
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= seq_item;
      s1_px   <= {pix.red, pix.green, pix.blue};
    end
    fwd_up  <= m_res;
    fwd_mid <= s1_px;
  end

  assign s1_wr = s1_valid && s1_item.wr;
  assign u_res = fwd_hit ? fwd_up : up_rdata;
  assign m_res = fwd_hit ? fwd_mid : mid_rdata;

  // new column entering the window
  always_comb begin
    new_col.mid = m_res;
    for (int k = 0; k < NUM_CHAN; k++) begin
      new_col.vsum[k] = VSUM_W'(pix_chan(u_res, k))
                      + VSUM_W'({pix_chan(m_res, k), 1'b0})
                      + VSUM_W'(pix_chan(s1_px, k));
    end
  end

  assign chain[0] = new_col;

  // window: a row of column cells
  for (genvar i = 0; i < WIN_COLS; i++) begin : g_cell
    gb3_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (s1_wr),
      .col_in (chain[i]),
      .col    (chain[i+1])
    );
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_item      <= s1_item;
    s2_drain_val <= (s1_item.kind == KIND_DRAIN_MID) ? m_res : u_res;
  end

  // row 1-2-1 over the column sums, divide by 16
  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      hsum[k] = HSUM_W'(chain[WIN_COLS].vsum[k])
              + HSUM_W'({chain[WIN_COLS-1].vsum[k], 1'b0})
              + HSUM_W'(chain[WIN_COLS-2].vsum[k]);
      blur_px[k*CHAN_W +: CHAN_W] = hsum[k][KERNEL_SHIFT +: CHAN_W];
    end
  end

  // result select
  always_comb begin
    case (s2_item.kind) inside
      KIND_BLUR:                     result_px = blur_px;
      KIND_CENTER:                   result_px = chain[WIN_COLS-1].mid;
      KIND_DRAIN_MID, KIND_DRAIN_UP: result_px = s2_drain_val;
    endcase
  end

  assign push                    = s2_valid && s2_item.emit;
  assign push_data.out_red       = pix_chan(result_px, CH_RED);
  assign push_data.out_green     = pix_chan(result_px, CH_GREEN);
  assign push_data.out_blue      = pix_chan(result_px, CH_BLUE);
  assign push_data.last_of_frame = s2_item.last;

  // result queue
  gb3_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .valid     (res_valid),
    .data      (res)
  );

  // a queued result always holds a credit
  a_push_credit: assert property (@(posedge clk) disable iff (rst)
    push |-> (occ != '0))
    else $error("result pushed without a credit");

  // the frame end is only reached while draining
  a_last_drain: assert property (@(posedge clk) disable iff (rst)
    (push && s2_item.last) |->
      (s2_item.kind == KIND_DRAIN_MID || s2_item.kind == KIND_DRAIN_UP))
    else $error("last_of_frame outside the drain phase");

  // a store write always comes from a pixel inside the frame
  a_write_kind: assert property (@(posedge clk) disable iff (rst)
    s1_wr |-> (s1_item.kind == KIND_BLUR || s1_item.kind == KIND_CENTER))
    else $error("line store written by a drain transaction");

endmodule

`default_nettype wire

// ----- tb/gaussian_blur_3x3_rgb_tb.sv -----
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_rgb_tb: self-checking bench for the 3x3 rgb gaussian blur
// Streams frames of random sizes and pixel content through the blur, with
// random gaps and stalls on both channels. Every input transaction runs
// through a bit-exact tracker of the line stores, the window and the frame
// counters. Each result is checked against the oldest expected pixel.
// ----------------------------------------------------------------------------

module gaussian_blur_3x3_rgb_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gb3_pkg::*;

  localparam int ITEM_BUDGET   = 1450;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;
  localparam int BIG_PIXELS    = 48;

  // tracks the blur state and holds the pixels the block still owes us
  class gauss_blur_tracker;
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    bit [PIX_W-1:0] upper_row [MAX_WIDTH];
    bit [PIX_W-1:0] middle_row [MAX_WIDTH];
    bit [PIX_W-1:0] win [3][3];
    int unsigned in_col, in_row, out_row, out_col;
    pixel_out_t pending_pixels[$];
    int failures;
    int checked;

    function new();
      width_reg  = CFG_WIDTH_W'(WIDTH_RESET);
      height_reg = CFG_HEIGHT_W'(HEIGHT_RESET);
      restart();
    endfunction

    function void restart();
      in_col  = 0;
      in_row  = 0;
      out_row = 0;
      out_col = 0;
    endfunction

    function int unsigned frame_width();
      if (width_reg == '0) return 1;
      if (32'(width_reg) > MAX_WIDTH) return MAX_WIDTH;
      return 32'(width_reg);
    endfunction

    function int unsigned frame_height();
      return (height_reg == '0) ? 1 : 32'(height_reg);
    endfunction

    function int backlog();
      return pending_pixels.size();
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg  = data[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_reg = data[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
      restart();
    endfunction

    function void fail(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
    endfunction

    // 1-2-1 x 1-2-1 kernel on each channel, divided by 16
    function bit [PIX_W-1:0] blur_window();
      bit [PIX_W-1:0] acc_pix;
      int acc;
      int i, j, k;
      acc_pix = '0;
      for (k = 0; k < NUM_CHAN; k++) begin
        acc = 0;
        for (i = 0; i < 3; i++)
          for (j = 0; j < 3; j++)
            acc += ((i == 1) ? 2 : 1) * ((j == 1) ? 2 : 1)
                 * int'(win[i][j][k*CHAN_W +: CHAN_W]);
        acc_pix[k*CHAN_W +: CHAN_W] = CHAN_W'(acc >> KERNEL_SHIFT);
      end
      return acc_pix;
    endfunction

    // advance the state by one accepted input transaction
    function void take_pixel(pixel_in_t item);
      int unsigned w, h, ic, ir, r, c;
      bit [PIX_W-1:0] px, above, mid, last_col_above, val;
      bit emit;
      int k;
      pixel_out_t want;
      w = frame_width();
      h = frame_height();
      if (in_row < h) begin
        // drains are ignored while pixels of the frame are still due
        if (item.operation == OP_DRAIN) return;
        ic = in_col % w;
        ir = in_row;
        px = {item.red, item.green, item.blue};
        last_col_above = upper_row[w-1];
        above = upper_row[ic];
        mid   = middle_row[ic];
        for (k = 0; k < 3; k++) begin
          win[k][0] = win[k][1];
          win[k][1] = win[k][2];
        end
        win[0][2] = above;
        win[1][2] = mid;
        win[2][2] = px;
        upper_row[ic]  = mid;
        middle_row[ic] = px;
        emit = (ir >= 2) || (ir == 1 && ic >= 1);
        if (ic + 1 >= w) begin
          in_col = 0;
          in_row = ir + 1;
        end else begin
          in_col = ic + 1;
        end
        if (!emit) return;
        r = out_row;
        c = out_col % w;
        if (w >= 3 && h >= 3 && r >= 1 && r + 2 <= h && c >= 1 && c + 2 <= w)
          val = blur_window();
        else if (c + 1 >= w)
          val = last_col_above;
        else
          val = win[1][1];
      end else begin
        // past the last pixel: any transaction flushes one stored pixel
        r = out_row;
        c = out_col % w;
        val = (r + 1 >= h) ? middle_row[c] : upper_row[c];
      end
      want.out_red       = val[CH_RED*CHAN_W +: CHAN_W];
      want.out_green     = val[CH_GREEN*CHAN_W +: CHAN_W];
      want.out_blue      = val[CH_BLUE*CHAN_W +: CHAN_W];
      want.last_of_frame = (r + 1 >= h) && (c + 1 >= w);
      pending_pixels.insert(pending_pixels.size(), want);
      if (want.last_of_frame) begin
        restart();
      end else if (c + 1 >= w) begin
        out_col = 0;
        out_row = r + 1;
      end else begin
        out_col = c + 1;
      end
    endfunction

    // compare one accepted result with the oldest expected pixel
    function void check_pixel(pixel_out_t got);
      pixel_out_t want;
      if (pending_pixels.size() == 0) begin
        fail($sformatf("unexpected result r=%02h g=%02h b=%02h last=%0d",
                       got.out_red, got.out_green, got.out_blue, got.last_of_frame));
        return;
      end
      want = pending_pixels.pop_front();
      checked++;
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue || got.last_of_frame !== want.last_of_frame)
        fail($sformatf({"result %0d mismatch: expected r=%02h g=%02h b=%02h last=%0d, ",
                        "got r=%02h g=%02h b=%02h last=%0d"},
                       checked, want.out_red, want.out_green, want.out_blue,
                       want.last_of_frame, got.out_red, got.out_green,
                       got.out_blue, got.last_of_frame));
    endfunction

    function void flush_leftovers();
      if (pending_pixels.size() != 0)
        fail($sformatf("%0d expected results never arrived", pending_pixels.size()));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  pix_valid;
  logic                  pix_stall;
  pixel_in_t             pix;
  logic                  res_valid;
  logic                  res_stall;
  pixel_out_t            res;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gauss_blur_tracker board;
  bit calm;
  bit hold_req;
  bit hold_off;
  int items_done;
  int items_ignored;
  int frames_done;
  int frames_cut;
  int reg_writes;

  gaussian_blur_3x3_rgb dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // idle length: mostly short, a few long
  function automatic int idle_len(input int pct_zero);
    int pick;
    if ($urandom_range(0, 99) < pct_zero) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CHAN_W-1:0] pick_chan();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_in_t make_item(input op_t op, input logic [CHAN_W-1:0] r,
                                          input logic [CHAN_W-1:0] g,
                                          input logic [CHAN_W-1:0] b);
    pixel_in_t item;
    item.operation = op;
    item.red       = r;
    item.green     = g;
    item.blue      = b;
    return item;
  endfunction

  function automatic pixel_in_t random_pixel();
    return make_item(OP_PIXEL, pick_chan(), pick_chan(), pick_chan());
  endfunction

  function automatic pixel_in_t random_drain();
    return make_item(OP_DRAIN, pick_chan(), pick_chan(), pick_chan());
  endfunction

  // offer one input transaction and wait until it is taken
  task automatic send_item(input pixel_in_t item);
    int gap;
    gap = calm ? 0 : idle_len(60);
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix       <= item;
    pix_valid <= 1'b1;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    board.take_pixel(item);
  endtask

  // wait until all owed results are in and the pipeline has emptied
  task automatic settle();
    pix_valid <= 1'b0;
    while (board.backlog() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_register(idx, data);
    reg_writes++;
  endtask

  task automatic set_frame_size(input bit wr_w, input bit wr_h,
                                input logic [CFG_DATA_W-1:0] w_data,
                                input logic [CFG_DATA_W-1:0] h_data);
    settle();
    if (wr_w) write_reg(REG_IMAGE_WIDTH, w_data);
    if (wr_h) write_reg(REG_IMAGE_HEIGHT, h_data);
    cfg_valid <= 1'b0;
  endtask

  // one frame: pixels, then the drain tail; noisy frames mix in ignored
  // drains and pixels that act as drains; a cut frame stops early
  task automatic run_frame(input bit cut, input bit noisy);
    int unsigned w, h;
    int npix, tail, i;
    w = board.frame_width();
    h = board.frame_height();
    npix = w * h;
    if (cut) npix = $urandom_range(0, npix - 1);
    for (i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) begin
        send_item(random_drain());
        items_ignored++;
      end
      send_item(random_pixel());
      items_done++;
    end
    if (cut) begin
      frames_cut++;
      return;
    end
    tail = (h == 1) ? w : w + 1;
    for (i = 0; i < tail; i++) begin
      send_item((noisy && $urandom_range(0, 1) == 1) ? random_pixel() : random_drain());
      items_done++;
    end
    if (noisy) begin
      repeat ($urandom_range(0, 2)) begin
        send_item(random_drain());
        items_ignored++;
      end
    end
    frames_done++;
  endtask

  // receiver: checks results and stalls at random
  initial begin : result_sink
    int run_len;
    bit stalling;
    run_len  = 0;
    stalling = 1'b0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) board.check_pixel(res);
      if (run_len == 0) begin
        if (!calm && !stalling && $urandom_range(0, 99) < 40) begin
          stalling = 1'b1;
          run_len  = idle_len(0);
        end else begin
          stalling = 1'b0;
          run_len  = $urandom_range(0, 12);
        end
      end else begin
        run_len--;
      end
      res_stall <= hold_off || (stalling && !calm);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin : receiver_hold
    hold_off <= 1'b0;
    forever begin
      wait (hold_req);
      @(posedge clk);
      hold_req = 1'b0;
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  // run limit
  initial begin : watchdog
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // stimulus
  initial begin : main_flow
    int i, pick, guard;
    logic [CFG_DATA_W-1:0] w_data, h_data;
    bit wr_w, wr_h;
    board = new();
    rst       <= 1'b1;
    pix_valid <= 1'b0;
    pix       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 4x3 frame: a white window but for one corner, a black corner in the
    // next window, ignored drain mid-frame, a pixel standing in for a drain
    set_frame_size(1'b1, 1'b1, 16'd4, 16'd3);
    for (i = 0; i < 12; i++) begin
      if (i == 5) send_item(make_item(OP_DRAIN, 8'h55, 8'hAA, 8'h0F));
      if (i == 3)
        send_item(make_item(OP_PIXEL, 8'h00, 8'h00, 8'h00));
      else if (i == 7)
        send_item(make_item(OP_PIXEL, 8'h01, 8'h80, 8'hFE));
      else if (i == 10)
        send_item(make_item(OP_PIXEL, 8'h7F, 8'h00, 8'h80));
      else
        send_item(make_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF));
    end
    send_item(make_item(OP_PIXEL, 8'hFF, 8'h00, 8'hFF));
    repeat (4) send_item(random_drain());
    send_item(random_drain());

    // zero sizes act as 1x1; upper bits of the width write are dropped
    set_frame_size(1'b1, 1'b1, 16'hF000, 16'h0000);
    send_item(make_item(OP_PIXEL, 8'h80, 8'h01, 8'hFE));
    send_item(random_drain());
    send_item(random_drain());

    // back-pressure: receiver holds off while the sender keeps going
    set_frame_size(1'b1, 1'b1, 16'd16, 16'd16);
    calm     = 1'b1;
    hold_req = 1'b1;
    run_frame(1'b0, 1'b0);
    calm = 1'b0;

    // widest and tallest setting: clamped width, partial frame
    set_frame_size(1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
    for (i = 0; i < BIG_PIXELS; i++) send_item(random_pixel());
    items_done += BIG_PIXELS;

    // random frames, mostly small
    while (items_done < ITEM_BUDGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       w_data = '0;
      else if (pick < 60) w_data = CFG_DATA_W'($urandom_range(1, 8));
      else if (pick < 92) w_data = CFG_DATA_W'($urandom_range(9, 24));
      else                w_data = CFG_DATA_W'($urandom_range(25, 80));
      pick = $urandom_range(0, 99);
      if (w_data > 24)    h_data = CFG_DATA_W'($urandom_range(0, 3));
      else if (pick < 5)  h_data = '0;
      else if (pick < 80) h_data = CFG_DATA_W'($urandom_range(1, 6));
      else                h_data = CFG_DATA_W'($urandom_range(7, 12));
      if ($urandom_range(0, 3) == 0)
        w_data[CFG_DATA_W-1:CFG_WIDTH_W] = (CFG_DATA_W-CFG_WIDTH_W)'($urandom_range(1, 15));
      pick = $urandom_range(0, 3);
      wr_w = (pick != 3) || (board.frame_width() > 24);
      wr_h = (pick != 2) || (board.frame_height() > 6);
      set_frame_size(wr_w, wr_h, w_data, h_data);
      calm = ($urandom_range(0, 9) == 0);
      repeat ($urandom_range(1, 3)) begin
        if (items_done >= ITEM_BUDGET) break;
        if ($urandom_range(0, 9) == 0) begin
          run_frame(1'b1, $urandom_range(0, 2) == 0);
          break;
        end
        run_frame(1'b0, $urandom_range(0, 2) == 0);
      end
      calm = 1'b0;
    end

    // wait out the last results
    pix_valid <= 1'b0;
    guard = 0;
    while (board.backlog() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    board.flush_leftovers();

    $display("ran %0d frames (%0d cut short), %0d transactions plus %0d ignored drains",
             frames_done, frames_cut, items_done, items_ignored);
    $display("%0d register writes, compared %0d result pixels, %0d failures",
             reg_writes, board.checked, board.failures);
    if (board.failures == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
